/* src/rdz_pkg.sv */
// ----------------------------------------------------------------------------
// rdz_pkg: shared constants of the radial dead zone scaler
// register indexes, reset values and output format widths
// ----------------------------------------------------------------------------
`default_nettype none
package rdz_pkg;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int REG_BITS        = 16;
   localparam int OUT_BITS        = 16;
   localparam int FRAC_BITS       = 15;
   localparam int QUOT_BITS       = 17;

   localparam logic REG_DEAD_ZONE  = 1'b0;
   localparam logic REG_FULL_SCALE = 1'b1;

   localparam logic [REG_BITS-1:0] DEAD_ZONE_RST  = 16'd8000;
   localparam logic [REG_BITS-1:0] FULL_SCALE_RST = 16'd32767;

   localparam logic [OUT_BITS-1:0] POS_MAX = 16'h7fff;
endpackage
`default_nettype wire

/* src/rdz_sqrt.sv */
// ----------------------------------------------------------------------------
// rdz_sqrt: pipelined integer square root
// one root bit per register stage, side data travels alongside
// ----------------------------------------------------------------------------
`default_nettype none
module rdz_sqrt #(
   parameter int ROOT_BITS = rdz_pkg::SAMPLE_BITS_DEF,
   parameter int SIDE_BITS = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [2*ROOT_BITS-1:0] in_radicand,
   input  wire logic [SIDE_BITS-1:0]   in_side,
   output logic                        out_valid,
   output logic [ROOT_BITS-1:0]        out_root,
   output logic [SIDE_BITS-1:0]        out_side
);
   localparam int RW = ROOT_BITS + 3;

   logic                   vld_st  [0:ROOT_BITS];
   logic [2*ROOT_BITS-1:0] rad_st  [0:ROOT_BITS];
   logic [ROOT_BITS-1:0]   root_st [0:ROOT_BITS];
   logic [RW-1:0]          rem_st  [0:ROOT_BITS];
   logic [SIDE_BITS-1:0]   side_st [0:ROOT_BITS];

   assign vld_st[0]  = in_valid;
   assign rad_st[0]  = in_radicand;
   assign root_st[0] = '0;
   assign rem_st[0]  = '0;
   assign side_st[0] = in_side;

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
      logic                   vld_ff;
      logic [2*ROOT_BITS-1:0] rad_ff;
      logic [ROOT_BITS-1:0]   root_ff;
      logic [RW-1:0]          rem_ff;
      logic [SIDE_BITS-1:0]   side_ff;
      logic [RW-1:0]          rem_sh;
      logic [RW-1:0]          trial;
      logic                   ge;

      assign rem_sh = {rem_st[j][RW-3:0], rad_st[j][2*ROOT_BITS-1 -: 2]};
      assign trial  = {1'b0, root_st[j], 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_st[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff  <= {rad_st[j][2*ROOT_BITS-3:0], 2'b00};
            root_ff <= {root_st[j][ROOT_BITS-2:0], ge};
            rem_ff  <= ge ? rem_sh - trial : rem_sh;
            side_ff <= side_st[j];
         end
      end

      assign vld_st[j+1]  = vld_ff;
      assign rad_st[j+1]  = rad_ff;
      assign root_st[j+1] = root_ff;
      assign rem_st[j+1]  = rem_ff;
      assign side_st[j+1] = side_ff;
   end

   assign out_valid = vld_st[ROOT_BITS];
   assign out_root  = root_st[ROOT_BITS];
   assign out_side  = side_st[ROOT_BITS];
endmodule
`default_nettype wire

/* src/rdz_div.sv */
// ----------------------------------------------------------------------------
// rdz_div: pipelined restoring divider
// one quotient bit per register stage, quotient known to fit QUOT_BITS
// ----------------------------------------------------------------------------
`default_nettype none
module rdz_div #(
   parameter int NUM_BITS  = 47,
   parameter int DEN_BITS  = 32,
   parameter int SIDE_BITS = 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire logic [NUM_BITS-1:0]         in_dividend,
   input  wire logic [DEN_BITS-1:0]         in_divisor,
   input  wire logic [SIDE_BITS-1:0]        in_side,
   output logic                             out_valid,
   output logic [rdz_pkg::QUOT_BITS-1:0]    out_quot,
   output logic [SIDE_BITS-1:0]             out_side
);
   localparam int QW = rdz_pkg::QUOT_BITS;
   localparam int CW = DEN_BITS + QW;

   logic                 vld_st  [0:QW];
   logic [NUM_BITS-1:0]  rem_st  [0:QW];
   logic [DEN_BITS-1:0]  div_st  [0:QW];
   logic [QW-1:0]        quot_st [0:QW];
   logic [SIDE_BITS-1:0] side_st [0:QW];

   assign vld_st[0]  = in_valid;
   assign rem_st[0]  = in_dividend;
   assign div_st[0]  = in_divisor;
   assign quot_st[0] = '0;
   assign side_st[0] = in_side;

   for (genvar j = 0; j < QW; j++) begin : g_stage
      logic                 vld_ff;
      logic [NUM_BITS-1:0]  rem_ff;
      logic [DEN_BITS-1:0]  div_ff;
      logic [QW-1:0]        quot_ff;
      logic [SIDE_BITS-1:0] side_ff;
      logic [CW-1:0]        rem_ext;
      logic [CW-1:0]        sub_val;
      logic                 ge;

      assign rem_ext = CW'(rem_st[j]);
      assign sub_val = CW'(div_st[j]) << (QW - 1 - j);
      assign ge      = rem_ext >= sub_val;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_st[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= ge ? NUM_BITS'(rem_ext - sub_val) : rem_st[j];
            div_ff  <= div_st[j];
            quot_ff <= {quot_st[j][QW-2:0], ge};
            side_ff <= side_st[j];
         end
      end

      assign vld_st[j+1]  = vld_ff;
      assign rem_st[j+1]  = rem_ff;
      assign div_st[j+1]  = div_ff;
      assign quot_st[j+1] = quot_ff;
      assign side_st[j+1] = side_ff;
   end

   assign out_valid = vld_st[QW];
   assign out_quot  = quot_st[QW];
   assign out_side  = side_st[QW];
endmodule
`default_nettype wire

/* src/radial_dead_zone_scale.sv */
// ----------------------------------------------------------------------------
// radial_dead_zone_scale: radial dead zone and rescale of a stick sample
// pipeline: square, sum, the square root stages, two scaling stages,
// 17 divider stages and the output register
// throughput one transfer per cycle; a held result stalls the whole pipeline
// synchronous reset clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none
module radial_dead_zone_scale #(
   parameter int SAMPLE_BITS = rdz_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // stick_x, stick_y, zero fill
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // out_x, out_y
   output logic [2*rdz_pkg::OUT_BITS-1:0]             rsp_tdata,
   // in_dead_zone
   output logic                                       rsp_tuser,
   input  wire logic                                  csr_we,
   input  wire logic                                  csr_index,
   input  wire logic [rdz_pkg::REG_BITS-1:0]          csr_wdata
);
   localparam int S   = SAMPLE_BITS;
   localparam int RB  = rdz_pkg::REG_BITS;
   localparam int OB  = rdz_pkg::OUT_BITS;
   localparam int QW  = rdz_pkg::QUOT_BITS;
   localparam int MW  = ((S > RB) ? S : RB) + 1;
   localparam int NW  = S + RB + rdz_pkg::FRAC_BITS;
   localparam int DW  = S + RB;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic [RB-1:0] dead_ff, full_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_ff <= rdz_pkg::DEAD_ZONE_RST;
         full_ff <= rdz_pkg::FULL_SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            rdz_pkg::REG_DEAD_ZONE:  dead_ff <= csr_wdata;
            rdz_pkg::REG_FULL_SCALE: full_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [S-1:0] in_x, in_y, ax_in, ay_in;
   assign in_x  = req_tdata[S-1:0];
   assign in_y  = req_tdata[2*S-1:S];
   assign ax_in = in_x[S-1] ? ~in_x + 1'b1 : in_x;
   assign ay_in = in_y[S-1] ? ~in_y + 1'b1 : in_y;

   // squares
   logic           s1_vld_ff;
   logic [2*S-1:0] s1_sqx_ff, s1_sqy_ff;
   logic [S-1:0]   s1_ax_ff, s1_ay_ff;
   logic           s1_nx_ff, s1_ny_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sqx_ff <= (2*S)'(ax_in) * (2*S)'(ax_in);
         s1_sqy_ff <= (2*S)'(ay_in) * (2*S)'(ay_in);
         s1_ax_ff  <= ax_in;
         s1_ay_ff  <= ay_in;
         s1_nx_ff  <= in_x[S-1];
         s1_ny_ff  <= in_y[S-1];
      end
   end

   // sum of squares
   logic           s2_vld_ff;
   logic [2*S-1:0] s2_sum_ff;
   logic [S-1:0]   s2_ax_ff, s2_ay_ff;
   logic           s2_nx_ff, s2_ny_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sum_ff <= s1_sqx_ff + s1_sqy_ff;
         s2_ax_ff  <= s1_ax_ff;
         s2_ay_ff  <= s1_ay_ff;
         s2_nx_ff  <= s1_nx_ff;
         s2_ny_ff  <= s1_ny_ff;
      end
   end

   logic              sq_vld;
   logic [S-1:0]      sq_len;
   logic [2*S+1:0]    sq_side;
   rdz_sqrt #(.ROOT_BITS(S), .SIDE_BITS(2*S+2)) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s2_vld_ff),
      .in_radicand (s2_sum_ff),
      .in_side     ({s2_ny_ff, s2_nx_ff, s2_ay_ff, s2_ax_ff}),
      .out_valid   (sq_vld),
      .out_root    (sq_len),
      .out_side    (sq_side)
   );

   // dead zone test and fraction terms
   logic [MW-1:0] len_ext, dead_ext, diff;
   logic [RB-1:0] den_in, num_in;
   logic          below_in;
   assign len_ext  = MW'(sq_len);
   assign dead_ext = MW'(dead_ff);
   assign below_in = len_ext < dead_ext;
   assign diff     = len_ext - dead_ext;
   assign den_in   = (full_ff > dead_ff) ? full_ff - dead_ff : RB'(1);
   // unit direction when full scale is not above the dead zone
   assign num_in   = (full_ff <= dead_ff) ? RB'(1)
                   : ((diff > MW'(den_in)) ? den_in : diff[RB-1:0]);

   logic           s3_vld_ff, s3_below_ff, s3_skip_ff;
   logic [RB-1:0]  s3_num_ff, s3_den_ff;
   logic [S-1:0]   s3_len_ff;
   logic [2*S+1:0] s3_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= sq_vld;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_below_ff <= below_in;
         s3_skip_ff  <= below_in || (sq_len == '0);
         s3_num_ff   <= num_in;
         s3_den_ff   <= den_in;
         s3_len_ff   <= sq_len;
         s3_side_ff  <= sq_side;
      end
   end

   // products for the division
   logic [S-1:0] s3_ax, s3_ay;
   assign s3_ax = s3_side_ff[S-1:0];
   assign s3_ay = s3_side_ff[2*S-1:S];

   logic          s4_vld_ff, s4_below_ff, s4_nx_ff, s4_ny_ff;
   logic [NW-1:0] s4_numx_ff, s4_numy_ff;
   logic [DW-1:0] s4_den_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_below_ff <= s3_below_ff;
         s4_nx_ff    <= s3_side_ff[2*S];
         s4_ny_ff    <= s3_side_ff[2*S+1];
         if (s3_skip_ff) begin
            s4_numx_ff <= '0;
            s4_numy_ff <= '0;
            s4_den_ff  <= DW'(1);
         end else begin
            s4_numx_ff <= {DW'(s3_ax) * DW'(s3_num_ff), {rdz_pkg::FRAC_BITS{1'b0}}};
            s4_numy_ff <= {DW'(s3_ay) * DW'(s3_num_ff), {rdz_pkg::FRAC_BITS{1'b0}}};
            s4_den_ff  <= DW'(s3_len_ff) * DW'(s3_den_ff);
         end
      end
   end

   logic          dx_vld, dy_vld;
   logic [QW-1:0] qx, qy;
   logic [1:0]    dx_side;
   logic          dy_side;
   rdz_div #(.NUM_BITS(NW), .DEN_BITS(DW), .SIDE_BITS(2)) u_div_x (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s4_vld_ff),
      .in_dividend (s4_numx_ff),
      .in_divisor  (s4_den_ff),
      .in_side     ({s4_below_ff, s4_nx_ff}),
      .out_valid   (dx_vld),
      .out_quot    (qx),
      .out_side    (dx_side)
   );
   rdz_div #(.NUM_BITS(NW), .DEN_BITS(DW), .SIDE_BITS(1)) u_div_y (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s4_vld_ff),
      .in_dividend (s4_numy_ff),
      .in_divisor  (s4_den_ff),
      .in_side     (s4_ny_ff),
      .out_valid   (dy_vld),
      .out_quot    (qy),
      .out_side    (dy_side)
   );

   // sign and saturation
   logic [QW-1:0] qx_neg, qy_neg;
   logic [OB-1:0] ox_in, oy_in;
   assign qx_neg = ~qx + 1'b1;
   assign qy_neg = ~qy + 1'b1;
   assign ox_in  = dx_side[0] ? qx_neg[OB-1:0]
                 : ((qx > QW'(rdz_pkg::POS_MAX)) ? rdz_pkg::POS_MAX : qx[OB-1:0]);
   assign oy_in  = dy_side ? qy_neg[OB-1:0]
                 : ((qy > QW'(rdz_pkg::POS_MAX)) ? rdz_pkg::POS_MAX : qy[OB-1:0]);

   logic          rsp_vld_ff, rsp_dz_ff;
   logic [OB-1:0] rsp_x_ff, rsp_y_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dx_vld && dy_vld;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_x_ff  <= ox_in;
         rsp_y_ff  <= oy_in;
         rsp_dz_ff <= dx_side[1];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_dz_ff;
endmodule
`default_nettype wire
